FILE: rtl/core/fec_pkg.sv
// ----------------------------------------------------------------------------
// fec_pkg
// Shared types, constants and the CRC-16 fold step for the frame encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fec_pkg;

    localparam logic [7:0]  SYNC_BYTE  = 8'h55;
    localparam logic [15:0] CRC_PRESET = 16'h6363;
    localparam logic [7:0]  LEN_MAX    = 8'hFF;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        OP_START,
        OP_DATA,
        OP_ERR
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] arg;
        logic [7:0] len;
        logic       last;
    } cmd_t;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] v);
        logic [7:0] b;
        b = v ^ crc[7:0];
        b = b ^ {b[3:0], 4'h0};
        return {8'h00, crc[15:8]} ^ {b, 8'h00} ^ {5'b00000, b, 3'b000}
            ^ {12'h000, b[7:4]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fec_front.sv
// ----------------------------------------------------------------------------
// fec_front
// Accepts input words, tracks the open frame and classifies each word into a
// start, data or error command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fec_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_action,
    input  wire logic [7:0]    s_frame_command,
    input  wire logic [7:0]    s_payload_length,
    input  wire logic [7:0]    s_payload_byte,
    output logic               q_push,
    output fec_pkg::cmd_t      q_data,
    input  wire logic          q_ready
);

    logic       frame_open_reg;
    logic       frame_open_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;

    assign s_ready = q_ready;
    assign q_push  = s_valid && q_ready;

    always_comb begin
        frame_open_next = frame_open_reg;
        bytes_left_next = bytes_left_reg;
        q_data.op   = fec_pkg::OP_ERR;
        q_data.arg  = 8'h00;
        q_data.len  = 8'h00;
        q_data.last = 1'b1;
        if (!s_action) begin
            q_data.op       = fec_pkg::OP_START;
            q_data.arg      = s_frame_command;
            q_data.len      = s_payload_length;
            q_data.last     = (s_payload_length == 8'h00);
            frame_open_next = (s_payload_length != 8'h00);
            bytes_left_next = s_payload_length;
        end else if (frame_open_reg) begin
            q_data.op       = fec_pkg::OP_DATA;
            q_data.arg      = s_payload_byte;
            q_data.last     = (bytes_left_reg == 8'h01);
            bytes_left_next = bytes_left_reg - 8'h01;
            frame_open_next = (bytes_left_reg != 8'h01);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b0;
            bytes_left_reg <= 8'h00;
        end else if (q_push) begin
            frame_open_reg <= frame_open_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fec_queue.sv
// ----------------------------------------------------------------------------
// fec_queue
// Small command queue between the front and back ends of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module fec_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire fec_pkg::cmd_t push_data,
    output logic               push_ready,
    output logic               pop_valid,
    output fec_pkg::cmd_t      pop_data,
    input  wire logic          pop
);

    fec_pkg::cmd_t             mem_reg [fec_pkg::QDEPTH];
    logic [fec_pkg::QAW-1:0]   wr_ptr_reg;
    logic [fec_pkg::QAW-1:0]   rd_ptr_reg;
    logic [fec_pkg::QAW:0]     count_reg;
    logic                      do_push;
    logic                      do_pop;

    assign push_ready = (count_reg != (fec_pkg::QAW+1)'(fec_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/fec_back.sv
// ----------------------------------------------------------------------------
// fec_back
// Executes queued commands one output word per cycle while the result channel
// is not stalled, keeps the running CRC-16 and drives the registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module fec_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_valid,
    input  wire fec_pkg::cmd_t q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_frame_end,
    output logic               m_run_last,
    output logic               m_error
);

    fec_pkg::cmd_t cur_reg;
    logic          cur_valid_reg;
    logic [2:0]    step_reg;
    logic [15:0]   crc_reg;
    logic [15:0]   crc_next;
    logic          m_valid_reg;
    logic [7:0]    m_out_byte_reg;
    logic          m_frame_end_reg;
    logic          m_run_last_reg;
    logic          m_error_reg;

    logic [7:0]    byte_c;
    logic          end_c;
    logic          last_c;
    logic          err_c;
    logic          fold_c;
    logic          preset_c;
    logic          advance;
    logic          fire;

    always_comb begin
        byte_c   = 8'h00;
        end_c    = 1'b0;
        last_c   = 1'b1;
        err_c    = 1'b0;
        fold_c   = 1'b0;
        preset_c = 1'b0;
        case (cur_reg.op)
            fec_pkg::OP_START: begin
                last_c = 1'b0;
                case (step_reg)
                    3'd0: begin
                        byte_c   = fec_pkg::SYNC_BYTE;
                        fold_c   = 1'b1;
                        preset_c = 1'b1;
                    end
                    3'd1: begin
                        byte_c = cur_reg.arg;
                        fold_c = 1'b1;
                    end
                    3'd2: begin
                        byte_c = cur_reg.len;
                        fold_c = 1'b1;
                    end
                    3'd3: begin
                        byte_c = fec_pkg::LEN_MAX - cur_reg.len;
                        fold_c = 1'b1;
                        last_c = !cur_reg.last;
                    end
                    3'd4: begin
                        byte_c = crc_reg[7:0];
                    end
                    default: begin
                        byte_c = crc_reg[15:8];
                        end_c  = 1'b1;
                        last_c = 1'b1;
                    end
                endcase
            end
            fec_pkg::OP_DATA: begin
                case (step_reg)
                    3'd0: begin
                        byte_c = cur_reg.arg;
                        fold_c = 1'b1;
                        last_c = !cur_reg.last;
                    end
                    3'd1: begin
                        byte_c = crc_reg[7:0];
                        last_c = 1'b0;
                    end
                    default: begin
                        byte_c = crc_reg[15:8];
                        end_c  = 1'b1;
                    end
                endcase
            end
            default: begin
                err_c = 1'b1;
            end
        endcase
    end

    always_comb begin
        crc_next = crc_reg;
        if (fold_c) begin
            crc_next = fec_pkg::crc_fold(preset_c ? fec_pkg::CRC_PRESET : crc_reg, byte_c);
        end
    end

    assign advance = !m_valid_reg || m_ready;
    assign fire    = cur_valid_reg && advance;
    assign q_pop   = q_valid && (!cur_valid_reg || (fire && last_c));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= 3'd0;
            crc_reg       <= fec_pkg::CRC_PRESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg <= 1'b1;
                crc_reg     <= crc_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                cur_valid_reg <= 1'b1;
                step_reg      <= 3'd0;
            end else begin
                if (fire) begin
                    step_reg <= step_reg + 3'd1;
                end
                if (fire && last_c) begin
                    cur_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cur_reg <= q_data;
        end
        if (fire) begin
            m_out_byte_reg  <= byte_c;
            m_frame_end_reg <= end_c;
            m_run_last_reg  <= last_c;
            m_error_reg     <= err_c;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_byte  = m_out_byte_reg;
    assign m_frame_end = m_frame_end_reg;
    assign m_run_last  = m_run_last_reg;
    assign m_error     = m_error_reg;

endmodule

`default_nettype wire

FILE: rtl/core/frame_encoder_crc_a_core.sv
// ----------------------------------------------------------------------------
// frame_encoder_crc_a_core
// Serial link frame builder with an ISO 14443-A CRC-16 over header and data.
//
// The input channel (s_) takes one word per cycle: a start word opens a frame
// and gives rise to the header 0x55, command, length and 0xFF minus length,
// followed by the CRC low and high bytes when the length is zero. A data word
// inside a frame gives its byte, and the CRC bytes after the last one. A data
// word outside a frame gives one word with the error flag set.
// The result channel (m_) delivers one output word per cycle; m_run_last marks
// the last output word of each input word and m_frame_end the CRC high byte.
// An input word passes through a queue entry and cur_reg before its first
// output word is registered. Input words enter at one per cycle while the
// four-entry command queue has room; sustained throughput is set by the back
// end, which emits one output word per cycle (a start word gives 4 or 6).
// A stalled receiver holds the output register; the back end then stops and
// the input channel stays ready until the queue fills. Reset empties the queue
// and the output register and closes any open frame.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_encoder_crc_a_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_action,
    input  wire logic [7:0]  s_frame_command,
    input  wire logic [7:0]  s_payload_length,
    input  wire logic [7:0]  s_payload_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_frame_end,
    output logic             m_run_last,
    output logic             m_error
);

    logic          push;
    fec_pkg::cmd_t push_data;
    logic          push_ready;
    logic          pop_valid;
    fec_pkg::cmd_t pop_data;
    logic          pop;

    fec_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_frame_command  (s_frame_command),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .q_push           (push),
        .q_data           (push_data),
        .q_ready          (push_ready)
    );

    fec_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop)
    );

    fec_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (pop_valid),
        .q_data      (pop_data),
        .q_pop       (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_frame_end (m_frame_end),
        .m_run_last  (m_run_last),
        .m_error     (m_error)
    );

endmodule

`default_nettype wire

FILE: verif/frame_encoder_crc_a_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_encoder_crc_a_core_test
// Self-checking bench for the framed CRC-16 encoder. Start and payload words
// go in over the s_ channel with random gaps, output words are taken from the
// m_ channel with random and one long stall, and a scoreboard predicts every
// output word with a bit-serial form of the ISO 14443-A CRC.
// ----------------------------------------------------------------------------

typedef struct {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
    logic       err;
} tx_word_t;

class frame_scoreboard;
    localparam bit ACT_START = 1'b0;

    logic [15:0] crc;
    logic [7:0]  bytes_left;
    bit          frame_open;
    tx_word_t    expected_words[$];
    int          errors;

    function new();
        crc        = fec_pkg::CRC_PRESET;
        bytes_left = 8'h00;
        frame_open = 1'b0;
        errors     = 0;
    endfunction

    function logic [15:0] crc_next(logic [15:0] c, logic [7:0] v);
        logic [15:0] r;
        r = c ^ {8'h00, v};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
        end
        return r;
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    function void note_input(bit action, logic [7:0] cmd, logic [7:0] len, logic [7:0] data);
        tx_word_t burst[6];
        logic [7:0] hdr[4];
        int n;
        n = 0;
        if (action == ACT_START) begin
            crc = fec_pkg::CRC_PRESET;
            hdr[0] = fec_pkg::SYNC_BYTE;
            hdr[1] = cmd;
            hdr[2] = len;
            hdr[3] = fec_pkg::LEN_MAX - len;
            for (int i = 0; i < 4; i++) begin
                burst[n] = '{hdr[i], 1'b0, 1'b0, 1'b0};
                crc = crc_next(crc, hdr[i]);
                n++;
            end
            bytes_left = len;
            frame_open = (len != 8'h00);
        end else if (!frame_open) begin
            burst[n] = '{8'h00, 1'b0, 1'b0, 1'b1};
            n++;
        end else begin
            burst[n] = '{data, 1'b0, 1'b0, 1'b0};
            crc = crc_next(crc, data);
            n++;
            bytes_left = bytes_left - 8'h01;
        end
        if (action == ACT_START ? (len == 8'h00) : (frame_open && bytes_left == 8'h00)) begin
            burst[n]     = '{crc[7:0], 1'b0, 1'b0, 1'b0};
            burst[n + 1] = '{crc[15:8], 1'b1, 1'b0, 1'b0};
            n += 2;
            frame_open = 1'b0;
            bytes_left = 8'h00;
        end
        burst[n - 1].run_last = 1'b1;
        for (int i = 0; i < n; i++) begin
            expected_words.push_back(burst[i]);
        end
    endfunction

    function void check_word(logic [7:0] data, logic frame_end, logic run_last, logic err);
        tx_word_t exp_w;
        if (expected_words.size() == 0) begin
            $display("%0t: unexpected word out_byte %02h frame_end %0b run_last %0b error %0b",
                     $time, data, frame_end, run_last, err);
            errors++;
            return;
        end
        exp_w = expected_words.pop_front();
        if (data !== exp_w.data) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_w.data, data);
            errors++;
        end
        if (frame_end !== exp_w.frame_end) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, exp_w.frame_end, frame_end);
            errors++;
        end
        if (run_last !== exp_w.run_last) begin
            $display("%0t: run_last expected %0b actual %0b", $time, exp_w.run_last, run_last);
            errors++;
        end
        if (err !== exp_w.err) begin
            $display("%0t: error expected %0b actual %0b", $time, exp_w.err, err);
            errors++;
        end
    endfunction
endclass

module frame_encoder_crc_a_core_test;

    localparam bit ACT_START   = 1'b0;
    localparam bit ACT_PAYLOAD = 1'b1;
    localparam int RANDOM_ITEMS = 370;
    localparam int TAIL_START   = 310;
    localparam int HOLD_AT      = 120;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 1000000;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic       s_action;
    logic [7:0] s_frame_command;
    logic [7:0] s_payload_length;
    logic [7:0] s_payload_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_frame_end;
    logic       m_run_last;
    logic       m_error;

    frame_scoreboard sb = new();
    int items_sent = 0;
    int cycles = 0;
    bit held = 1'b0;

    frame_encoder_crc_a_core i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_frame_command  (s_frame_command),
        .s_payload_length (s_payload_length),
        .s_payload_byte   (s_payload_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_byte       (m_out_byte),
        .m_frame_end      (m_frame_end),
        .m_run_last       (m_run_last),
        .m_error          (m_error)
    );

    initial begin
        aclk             = 1'b0;
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_action         = ACT_START;
        s_frame_command  = 8'h00;
        s_payload_length = 8'h00;
        s_payload_byte   = 8'h00;
        m_ready          = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("frame_encoder_crc_a_core_test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_word(m_out_byte, m_frame_end, m_run_last, m_error);
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_word(input bit action, input logic [7:0] cmd, input logic [7:0] len,
                             input logic [7:0] data);
        if (items_sent < TAIL_START && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_action         <= action;
        s_frame_command  <= cmd;
        s_payload_length <= len;
        s_payload_byte   <= data;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(action, cmd, len, data);
        items_sent++;
        @(negedge aclk);
    endtask

    // Opens a frame and sends up to send_count of its payload words.
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input int send_count);
        send_word(ACT_START, cmd, len, 8'($urandom));
        for (int i = 0; i < len && i < send_count && items_sent < RANDOM_ITEMS; i++) begin
            send_word(ACT_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        forever begin
            @(negedge aclk);
            if (!held && items_sent >= HOLD_AT) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                held = 1'b1;
            end else if (items_sent < TAIL_START && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [7:0] len;
        int pick;
        repeat (11) @(negedge aclk);

        // Payload with no open frame, empty frames, complete frames, and frames cut short by a new start.
        send_word(ACT_PAYLOAD, 8'hFF, 8'hFF, 8'hFF);
        send_word(ACT_START, 8'h00, 8'h00, 8'h00);
        send_word(ACT_START, 8'hFF, 8'h00, 8'hFF);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00);
        send_word(ACT_START, 8'hA5, 8'h01, 8'h00);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'hFF);
        send_word(ACT_START, 8'h3C, 8'h03, 8'h00);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h00);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h5A);
        send_word(ACT_START, 8'h0F, 8'h02, 8'h00);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h80);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h7F);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h55);
        send_word(ACT_START, 8'h81, 8'hFF, 8'h00);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'hC3);
        send_word(ACT_PAYLOAD, 8'h00, 8'h00, 8'h3C);
        send_word(ACT_START, 8'h7E, 8'h00, 8'h00);

        while (items_sent < RANDOM_ITEMS) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 7) begin
                len = ($urandom_range(0, 39) == 0) ? 8'($urandom_range(8, 255))
                                                   : 8'($urandom_range(0, 7));
                send_frame(8'($urandom), len, int'(len));
            end else if (pick < 9) begin
                len = 8'($urandom);
                send_frame(8'($urandom), len, int'($urandom_range(0, 3)));
            end else begin
                send_word(ACT_PAYLOAD, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("frame_encoder_crc_a_core_test passed");
        end else begin
            $display("frame_encoder_crc_a_core_test failed");
        end
        $finish;
    end

endmodule
